@@ rtl/kskp_pkg.sv @@
// ----------------------------------------------------------------------------
// kskp_pkg
// Shared types and constants for the k-smallest keeper and its cells.
// ----------------------------------------------------------------------------
package kskp_pkg;

  localparam int unsigned DefCapacity = 32;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned LimitW      = 6;

  localparam logic [LimitW-1:0] KeepLimitReset = 6'd32;

  // operation codes
  localparam logic OpInsert = 1'b0;
  localparam logic OpDrain  = 1'b1;

  typedef logic [ValueW-1:0] value_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // insert the broadcast value into the sorted chain
    logic grow;  // the chain may take one more entry
    logic shl;   // shift everything toward cell 0 (drain)
  } cell_ctrl_t;

endpackage

@@ rtl/kskp_cell.sv @@
// ----------------------------------------------------------------------------
// kskp_cell
// One entry of the ascending chain: holds a value and a valid flag, takes
// its neighbor's value on an insert that moves past it or on a drain shift.
// ----------------------------------------------------------------------------
module kskp_cell
  import kskp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  value_t     ins_value_i,
  input  value_t     left_value_i,
  input  logic       left_valid_i,
  input  logic       left_gt_i,
  input  value_t     right_value_i,
  input  logic       right_valid_i,
  output value_t     value_o,
  output logic       valid_o,
  output logic       gt_o
);

  value_t value_q, value_d;
  logic   valid_q, valid_d;
  logic   take;

  assign gt_o    = valid_q && (value_q > ins_value_i);
  assign value_o = value_q;
  assign valid_o = valid_q;

  // an entry moves here when this cell holds a larger value, or when this is
  // the first free cell and the chain grows
  assign take = gt_o || (ctrl_i.grow && left_valid_i && !valid_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.shl) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.ins && take) begin
      value_d = left_gt_i ? left_value_i : ins_value_i;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

@@ rtl/k_smallest_keeper.sv @@
// ----------------------------------------------------------------------------
// k_smallest_keeper
// Keeps the smallest values of a stream in a sorted chain of cells.
// ----------------------------------------------------------------------------
// An insert yields no word: every cell compares the new value with its own at
// once and the chain opens a slot in place, so inserts may arrive back to back.
// At the limit (keep_limit, saturated at CAPACITY) a value strictly below the
// largest held one pushes that one out of the chain; a keep_limit of zero drops
// every insert. On a drain the chain shifts toward cell 0 once per word taken at
// the output register, ascending, with last on the final word; an empty store
// gives a single word with empty_res set.
// No item is accepted while a drain is shifting out.
module k_smallest_keeper
  import kskp_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValueW-1:0] value_out_o,
  output logic              last_o,
  output logic              empty_res_o,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > LimitW) ? CntW : LimitW;
  localparam logic [CmpW-1:0] CapCmp = CmpW'(CAPACITY);

  localparam logic StIdle  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic              state_q, state_d;
  logic [LimitW-1:0] limit_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q, out_valid_d;
  value_t            out_value_q, out_value_d;
  logic              out_last_q, out_last_d;
  logic              out_empty_q, out_empty_d;

  cell_ctrl_t ctrl;
  value_t     cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_gt;

  logic in_acc, ins, grow, pop, pop_last, next_valid;
  logic [CmpW-1:0] count_ext, limit_ext;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign count_ext  = CmpW'(count_q);
  assign limit_ext  = CmpW'(limit_q);

  assign ins  = in_acc && (operation_i == OpInsert) && (limit_q != '0);
  assign grow = (count_ext < limit_ext) && (count_ext < CapCmp);
  assign pop  = (state_q == StDrain) && (!out_valid_q || out_ready_i);

  assign next_valid = (CAPACITY > 1) ? cell_valid[CAPACITY > 1 ? 1 : 0] : 1'b0;
  assign pop_last   = !cell_valid[0] || !next_valid;

  assign ctrl.ins  = ins;
  assign ctrl.grow = grow;
  assign ctrl.shl  = pop;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    value_t lv, rv;
    logic   lvd, lgt, rvd;
    if (g == 0) begin : g_head
      assign lv  = '0;
      assign lvd = 1'b1;
      assign lgt = 1'b0;
    end else begin : g_mid
      assign lv  = cell_value[g-1];
      assign lvd = cell_valid[g-1];
      assign lgt = cell_gt[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign rv  = '0;
      assign rvd = 1'b0;
    end else begin : g_body
      assign rv  = cell_value[g+1];
      assign rvd = cell_valid[g+1];
    end
    kskp_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .ins_value_i   (value_i),
      .left_value_i  (lv),
      .left_valid_i  (lvd),
      .left_gt_i     (lgt),
      .right_value_i (rv),
      .right_valid_i (rvd),
      .value_o       (cell_value[g]),
      .valid_o       (cell_valid[g]),
      .gt_o          (cell_gt[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_acc && (operation_i == OpDrain)) begin
          state_d = StDrain;
          count_d = '0;
        end else if (ins && grow) begin
          count_d = count_q + 1'b1;
        end
      end
      StDrain: begin
        if (pop) begin
          out_valid_d = 1'b1;
          out_value_d = cell_valid[0] ? cell_value[0] : '0;
          out_last_d  = pop_last;
          out_empty_d = !cell_valid[0];
          if (pop_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      limit_q     <= KeepLimitReset;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_value_q;
  assign last_o      = out_last_q;
  assign empty_res_o = out_empty_q;

  // the held count and the head cell agree whenever no drain is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> ((count_q != '0) == cell_valid[0]))
    else $error("held count and head cell disagree");

  // the chain stays packed toward cell 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_valid + 1'b1) || (cell_valid == '0) || (&cell_valid))
    else $error("chain valid bits are not packed");

  // the count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= CapCmp)
    else $error("held count above capacity");

  // the final word of a drain returns the block to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && pop_last) |=> (state_q == StIdle) && out_valid_q && out_last_q)
    else $error("drain did not end on its last word");

endmodule
